// File: src/tts_pkg.sv
// Shared types and constants for the text terminal screen engine.
package tts_pkg;

	localparam int Columns  = 80;
	localparam int Rows     = 24;
	localparam int TabWidth = 8;
	localparam int ColW     = 7;
	localparam int RowW     = 5;
	localparam int Cells    = Rows * Columns;
	localparam int AddrW    = $clog2(Cells);
	localparam int CellW    = 20;

	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [3:0] RESET_FG   = 4'd7;

	localparam logic [3:0] REQ_PUT    = 4'd0;
	localparam logic [3:0] REQ_TAB    = 4'd1;
	localparam logic [3:0] REQ_FF     = 4'd2;
	localparam logic [3:0] REQ_MOVE   = 4'd3;
	localparam logic [3:0] REQ_CLRLN  = 4'd4;
	localparam logic [3:0] REQ_CLRSCR = 4'd5;
	localparam logic [3:0] REQ_SCRUP  = 4'd6;
	localparam logic [3:0] REQ_SCRDN  = 4'd7;
	localparam logic [3:0] REQ_WIN    = 4'd8;
	localparam logic [3:0] REQ_READ   = 4'd9;

	localparam logic [3:0] CFG_WRAP  = 4'd0;
	localparam logic [3:0] CFG_FG    = 4'd1;
	localparam logic [3:0] CFG_BG    = 4'd2;
	localparam logic [3:0] CFG_STYLE = 4'd3;

	typedef struct packed {
		logic [3:0]        style;
		logic [3:0]        bg;
		logic [3:0]        fg;
		logic [7:0]        ch;
	} cell_t;

	typedef struct packed {
		logic [3:0]        req_type;
		logic [7:0]        char_code;
		logic signed [7:0] col_arg;
		logic signed [7:0] row_arg;
		logic              direction;
		logic              scroll_enable;
		logic [4:0]        region_bottom;
	} req_t;

	typedef struct packed {
		logic [ColW-1:0] cursor_col;
		logic [RowW-1:0] cursor_row;
		logic [7:0]      cell_char;
		logic [3:0]      cell_fg;
		logic [3:0]      cell_bg;
		logic [3:0]      cell_style;
	} rsp_t;

	typedef struct packed {
		logic [3:0] index;
		logic [3:0] data;
	} cfg_t;

endpackage

// File: src/tts_if.sv
// Valid/ready channel interfaces for requests, responses and register writes.
interface tts_req_if;
	logic            valid;
	logic            ready;
	tts_pkg::req_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tts_rsp_if;
	logic            valid;
	logic            ready;
	tts_pkg::rsp_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tts_cfg_if;
	logic            valid;
	logic            ready;
	tts_pkg::cfg_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/text_terminal_screen_engine_core.sv
// Top level of the text terminal screen engine: command sequencer around the cell RAM.
// Put char, tab, move, set window and unused codes go from idle to the output state,
// unless a put wraps on the last row or a move scrolls. Read cell adds a capture state.
// Scrolls rotate the row map, then blank one physical row. One command at a time. Clears
// read and rewrite each cell via the single RAM port pair: a read then a write state.
// After reset a sweep writes 1920 blank cells, one per cycle, before the first request beat.
module text_terminal_screen_engine_core (
	input logic        clk,
	input logic        arst_n,
	tts_req_if.sink    req,
	tts_rsp_if.source  rsp,
	tts_cfg_if.sink    cfg
);
	localparam int ColW  = tts_pkg::ColW;
	localparam int RowW  = tts_pkg::RowW;
	localparam int AddrW = tts_pkg::AddrW;
	localparam logic [ColW-1:0] LastCol = ColW'(tts_pkg::Columns - 1);
	localparam logic [RowW-1:0] LastRow = RowW'(tts_pkg::Rows - 1);

	typedef enum logic [2:0] {
		S_INIT, S_IDLE, S_BRD, S_BWR, S_RCAP, S_SCR, S_FRESH, S_OUT
	} state_t;

	state_t             state_q;
	logic [AddrW-1:0]   init_q;
	logic               wrap_q;
	logic [3:0]         fg_q, bg_q, style_q;
	logic [ColW-1:0]    col_q;
	logic [RowW-1:0]    row_q;
	logic [RowW-1:0]    top_q, bot_q;
	logic [RowW-1:0]    map_q [tts_pkg::Rows];
	logic [RowW-1:0]    wrow_q, erow_q, fresh_q;
	logic [ColW-1:0]    wcol_q, ecol_q;
	logic [AddrW-1:0]   addr_q;
	logic               dn_q;
	tts_pkg::cell_t     cell_q;
	logic               out_valid_q;
	tts_pkg::rsp_t      rsp_q;
	logic               out_load;

	logic               we;
	logic [AddrW-1:0]   waddr, raddr, map_addr;
	tts_pkg::cell_t     wdata, rdata;
	logic [RowW-1:0]    map_idx, map_rd;
	logic [ColW-1:0]    addr_col;
	logic               accept;
	tts_pkg::req_t      rq;

	logic signed [8:0]  rs, cs;
	logic               line_ok;
	logic               clr_go;
	logic [RowW-1:0]    clr_srow, clr_erow;
	logic [ColW-1:0]    clr_scol, clr_ecol;
	logic [ColW-1:0]    mv_col;
	logic [RowW-1:0]    mv_row;
	logic               mv_up, mv_dn;
	logic signed [8:0]  win_t, win_b, bot_s;

	assign rq      = req.data;
	assign accept  = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = rsp_q;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || rsp.ready);

	assign rs      = 9'(rq.row_arg);
	assign cs      = 9'(rq.col_arg);
	assign line_ok = (rs >= 0) && (rs < tts_pkg::Rows) && (cs >= 0) && (cs < tts_pkg::Columns);

	always_comb begin
		clr_go   = 1'b0;
		clr_srow = '0;
		clr_scol = '0;
		clr_erow = LastRow;
		clr_ecol = LastCol;
		case (rq.req_type)
			tts_pkg::REQ_FF: begin
				clr_go = 1'b1;
			end
			tts_pkg::REQ_CLRLN: begin
				clr_go   = line_ok;
				clr_srow = RowW'(rs);
				clr_erow = RowW'(rs);
				clr_scol = rq.direction ? ColW'(cs) : '0;
				clr_ecol = rq.direction ? LastCol : ColW'(cs);
			end
			tts_pkg::REQ_CLRSCR: begin
				if (rq.direction) begin
					if (line_ok) begin
						clr_go   = 1'b1;
						clr_srow = RowW'(rs);
						clr_scol = ColW'(cs);
					end else if (rs < 0) begin
						clr_go = 1'b1;
					end else begin
						clr_go   = (rs + 9'sd1) < tts_pkg::Rows;
						clr_srow = RowW'(rs + 9'sd1);
					end
				end else begin
					if (line_ok) begin
						clr_go   = 1'b1;
						clr_erow = RowW'(rs);
						clr_ecol = ColW'(cs);
					end else if (rs >= tts_pkg::Rows) begin
						clr_go = 1'b1;
					end else begin
						clr_go   = (rs - 9'sd1) >= 0;
						clr_erow = RowW'(rs - 9'sd1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign win_t = 9'(top_q);
	assign win_b = 9'(bot_q);
	assign bot_s = 9'(rq.region_bottom);

	always_comb begin
		if (cs < 1) begin
			mv_col = '0;
		end else if (cs > tts_pkg::Columns) begin
			mv_col = LastCol;
		end else begin
			mv_col = ColW'(cs - 9'sd1);
		end
		mv_up = 1'b0;
		mv_dn = 1'b0;
		if (rs < win_t + 9'sd1) begin
			mv_row = top_q;
			mv_dn  = 1'b1;
		end else if (rs > win_b + 9'sd1) begin
			mv_row = bot_q;
			mv_up  = 1'b1;
		end else begin
			mv_row = RowW'(rs - 9'sd1);
		end
	end

	always_comb begin
		map_idx  = wrow_q;
		addr_col = wcol_q;
		if (state_q == S_IDLE) begin
			map_idx  = (rq.req_type == tts_pkg::REQ_PUT) ? row_q : RowW'(rs);
			addr_col = (rq.req_type == tts_pkg::REQ_PUT) ? col_q : ColW'(cs);
		end else if (state_q == S_SCR) begin
			map_idx = dn_q ? bot_q : top_q;
		end
	end

	assign map_rd   = (map_idx < RowW'(tts_pkg::Rows)) ? map_q[map_idx] : '0;
	assign map_addr = AddrW'(map_rd) * AddrW'(tts_pkg::Columns) + AddrW'(addr_col);
	assign raddr    = map_addr;

	always_comb begin
		we    = 1'b0;
		waddr = map_addr;
		wdata = '{style: 4'd0, bg: bg_q, fg: fg_q, ch: tts_pkg::BLANK_CHAR};
		unique case (state_q)
			S_INIT: begin
				we    = 1'b1;
				waddr = init_q;
				wdata = '{style: 4'd0, bg: 4'd0, fg: tts_pkg::RESET_FG,
					ch: tts_pkg::BLANK_CHAR};
			end
			S_IDLE: begin
				we    = accept && (rq.req_type == tts_pkg::REQ_PUT);
				wdata = '{style: style_q, bg: bg_q, fg: fg_q, ch: rq.char_code};
			end
			S_BWR: begin
				we    = 1'b1;
				waddr = addr_q;
				wdata = '{style: 4'd0, bg: bg_q, fg: rdata.fg, ch: tts_pkg::BLANK_CHAR};
			end
			S_FRESH: begin
				we    = 1'b1;
				waddr = AddrW'(fresh_q) * AddrW'(tts_pkg::Columns) + AddrW'(wcol_q);
			end
			default: begin
			end
		endcase
	end

	tts_ram #(
		.Width (tts_pkg::CellW),
		.Depth (tts_pkg::Cells)
	) u_cells (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q  <= 1'b1;
			fg_q    <= tts_pkg::RESET_FG;
			bg_q    <= '0;
			style_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.data.index)
				tts_pkg::CFG_WRAP:  wrap_q  <= cfg.data.data[0];
				tts_pkg::CFG_FG:    fg_q    <= cfg.data.data;
				tts_pkg::CFG_BG:    bg_q    <= cfg.data.data;
				tts_pkg::CFG_STYLE: style_q <= cfg.data.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			rsp_q       <= '{cursor_col: col_q, cursor_row: row_q, cell_char: cell_q.ch,
				cell_fg: cell_q.fg, cell_bg: cell_q.bg, cell_style: cell_q.style};
		end else if (rsp.valid && rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_q      <= '0;
			col_q       <= '0;
			row_q       <= '0;
			top_q       <= '0;
			bot_q       <= LastRow;
			dn_q        <= 1'b0;
			wrow_q      <= '0;
			erow_q      <= '0;
			fresh_q     <= '0;
			wcol_q      <= '0;
			ecol_q      <= '0;
			addr_q      <= '0;
			cell_q      <= '0;
			for (int i = 0; i < tts_pkg::Rows; i++) begin
				map_q[i] <= RowW'(i);
			end
		end else begin
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == AddrW'(tts_pkg::Cells - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cell_q  <= '0;
						state_q <= S_OUT;
						case (rq.req_type)
							tts_pkg::REQ_PUT: begin
								if (col_q >= LastCol) begin
									if (wrap_q) begin
										col_q <= '0;
										if (row_q < LastRow) begin
											row_q <= row_q + 1'b1;
										end else begin
											dn_q    <= 1'b0;
											state_q <= S_SCR;
										end
									end
								end else begin
									col_q <= col_q + 1'b1;
								end
							end
							tts_pkg::REQ_TAB: begin
								if (col_q < ColW'(tts_pkg::Columns - tts_pkg::TabWidth)) begin
									col_q <= col_q + ColW'(tts_pkg::TabWidth)
										- (col_q % ColW'(tts_pkg::TabWidth));
								end else begin
									col_q <= LastCol;
								end
							end
							tts_pkg::REQ_FF, tts_pkg::REQ_CLRLN, tts_pkg::REQ_CLRSCR: begin
								if (rq.req_type == tts_pkg::REQ_FF) begin
									col_q <= '0;
									row_q <= '0;
								end
								wrow_q <= clr_srow;
								wcol_q <= clr_scol;
								erow_q <= clr_erow;
								ecol_q <= clr_ecol;
								if (clr_go) begin
									state_q <= S_BRD;
								end
							end
							tts_pkg::REQ_MOVE: begin
								col_q <= mv_col;
								row_q <= mv_row;
								dn_q  <= mv_dn;
								if (rq.scroll_enable && (mv_up || mv_dn)) begin
									state_q <= S_SCR;
								end
							end
							tts_pkg::REQ_SCRUP: begin
								dn_q    <= 1'b1;
								state_q <= S_SCR;
							end
							tts_pkg::REQ_SCRDN: begin
								dn_q    <= 1'b0;
								state_q <= S_SCR;
							end
							tts_pkg::REQ_WIN: begin
								if ((rs < 1 ? 9'sd1 : (rs > tts_pkg::Rows ? 9'(tts_pkg::Rows) : rs))
									<= (bot_s < 1 ? 9'sd1
									: (bot_s > tts_pkg::Rows ? 9'(tts_pkg::Rows) : bot_s))) begin
									col_q <= '0;
									row_q <= mv_row;
									top_q <= (rs < 1) ? '0
										: (rs > tts_pkg::Rows) ? LastRow : RowW'(rs - 9'sd1);
									bot_q <= (bot_s < 1) ? '0
										: (bot_s > tts_pkg::Rows) ? LastRow : RowW'(bot_s - 9'sd1);
								end
							end
							tts_pkg::REQ_READ: begin
								if (line_ok) begin
									state_q <= S_RCAP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_BRD: begin
					addr_q  <= map_addr;
					state_q <= S_BWR;
				end
				S_BWR: begin
					if (wrow_q == erow_q && wcol_q == ecol_q) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_BRD;
						if (wcol_q == LastCol) begin
							wcol_q <= '0;
							wrow_q <= wrow_q + 1'b1;
						end else begin
							wcol_q <= wcol_q + 1'b1;
						end
					end
				end
				S_RCAP: begin
					cell_q  <= rdata;
					state_q <= S_OUT;
				end
				S_SCR: begin
					fresh_q <= map_rd;
					wcol_q  <= '0;
					state_q <= S_FRESH;
					for (int i = 0; i < tts_pkg::Rows; i++) begin
						if (dn_q) begin
							if (RowW'(i) == top_q) begin
								map_q[i] <= map_rd;
							end else if (i > 0 && RowW'(i) > top_q && RowW'(i) <= bot_q) begin
								map_q[i] <= map_q[(i > 0) ? i - 1 : 0];
							end
						end else begin
							if (RowW'(i) == bot_q) begin
								map_q[i] <= map_rd;
							end else if (i < tts_pkg::Rows - 1 && RowW'(i) >= top_q
								&& RowW'(i) < bot_q) begin
								map_q[i] <= map_q[(i < tts_pkg::Rows - 1) ? i + 1 : i];
							end
						end
					end
				end
				S_FRESH: begin
					wcol_q <= wcol_q + 1'b1;
					if (wcol_q == LastCol) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> !req.ready)
		else $error("request beat taken while a command is in flight");
	assert property (@(posedge clk) disable iff (!arst_n) top_q <= bot_q)
		else $error("scroll window top below bottom");
	assert property (@(posedge clk) disable iff (!arst_n) row_q <= LastRow && col_q <= LastCol)
		else $error("cursor off screen");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && (!out_valid_q || rsp.ready)) |=> rsp.valid)
		else $error("finished command produced no response beat");
`endif
endmodule

// File: src/tts_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module tts_ram #(
	parameter int Width = 20,
	parameter int Depth = 1920
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: verif/tb_text_terminal_screen_engine_core.sv
// Self-checking testbench for the text terminal screen engine: random and directed commands.
module tb_text_terminal_screen_engine_core;
	import tts_pkg::*;

	class screen_scoreboard;
		cell_t     cells[Cells];
		int        rmap[Rows];
		int        ccol, crow, wtop, wbot;
		bit        wrap;
		bit [3:0]  fg, bg, sty;
		rsp_t      pending[$];
		int        errors;

		function void clear_all();
			for (int i = 0; i < Rows; i++) rmap[i] = i;
			for (int i = 0; i < Cells; i++) cells[i] = {4'd0, 4'd0, RESET_FG, BLANK_CHAR};
			ccol = 0; crow = 0; wtop = 0; wbot = Rows - 1;
			wrap = 1; fg = RESET_FG; bg = 0; sty = 0;
			errors = 0;
		endfunction

		function int addr(int r, int c);
			return rmap[r] * Columns + c;
		endfunction

		function void blank_cell(int r, int c);
			int a;
			a = addr(r, c);
			cells[a] = {4'd0, bg, cells[a].fg, BLANK_CHAR};
		endfunction

		function void blank_row(int r);
			for (int j = 0; j < Columns; j++) blank_cell(r, j);
		endfunction

		function void fresh_row(int p);
			for (int j = 0; j < Columns; j++) cells[p * Columns + j] = {4'd0, bg, fg, BLANK_CHAR};
		endfunction

		function void lines_up();
			int p;
			p = rmap[wtop];
			for (int i = wtop; i < wbot; i++) rmap[i] = rmap[i + 1];
			rmap[wbot] = p;
			fresh_row(p);
		endfunction

		function void lines_down();
			int p;
			p = rmap[wbot];
			for (int i = wbot; i > wtop; i--) rmap[i] = rmap[i - 1];
			rmap[wtop] = p;
			fresh_row(p);
		endfunction

		function void move_cursor(int c, int r, bit scr);
			if (c < 1) ccol = 0;
			else if (c > Columns) ccol = Columns - 1;
			else ccol = c - 1;
			if (r < wtop + 1) begin
				crow = wtop;
				if (scr) lines_down();
			end else if (r > wbot + 1) begin
				crow = wbot;
				if (scr) lines_up();
			end else begin
				crow = r - 1;
			end
		endfunction

		function void clear_line_part(int c, int r, bit to_end);
			if (r < 0 || r >= Rows || c < 0 || c >= Columns) return;
			if (to_end) for (int j = c; j < Columns; j++) blank_cell(r, j);
			else for (int j = c; j >= 0; j--) blank_cell(r, j);
		endfunction

		function void write_reg(logic [3:0] idx, logic [3:0] v);
			case (idx)
				CFG_WRAP: wrap = v[0];
				CFG_FG: fg = v;
				CFG_BG: bg = v;
				CFG_STYLE: sty = v;
				default: ;
			endcase
		endfunction

		function void note_request(req_t q);
			int c, r, t, b;
			cell_t rd;
			rsp_t e;
			c = int'(q.col_arg);
			r = int'(q.row_arg);
			rd = '0;
			case (q.req_type)
				REQ_PUT: begin
					cells[addr(crow, ccol)] = {sty, bg, fg, q.char_code};
					if (ccol >= Columns - 1) begin
						if (wrap) begin
							ccol = 0;
							if (crow < Rows - 1) crow++;
							else lines_up();
						end
					end else ccol++;
				end
				REQ_TAB: begin
					if (ccol < Columns - TabWidth) ccol += TabWidth - ccol % TabWidth;
					else ccol = Columns - 1;
				end
				REQ_FF: begin
					for (int i = 0; i < Rows; i++) blank_row(i);
					ccol = 0; crow = 0;
				end
				REQ_MOVE: move_cursor(c, r, q.scroll_enable);
				REQ_CLRLN: clear_line_part(c, r, q.direction);
				REQ_CLRSCR: begin
					clear_line_part(c, r, q.direction);
					if (q.direction) begin
						for (int i = (r < 0 ? 0 : r + 1); i < Rows; i++) blank_row(i);
					end else begin
						for (int i = (r > Rows ? Rows - 1 : r - 1); i >= 0; i--) blank_row(i);
					end
				end
				REQ_SCRUP: lines_down();
				REQ_SCRDN: lines_up();
				REQ_WIN: begin
					t = r < 1 ? 1 : (r > Rows ? Rows : r);
					b = q.region_bottom < 1 ? 1 : (q.region_bottom > Rows ? Rows : q.region_bottom);
					if (t <= b) begin
						move_cursor(1, r, 0);
						wtop = t - 1;
						wbot = b - 1;
					end
				end
				REQ_READ: if (r >= 0 && r < Rows && c >= 0 && c < Columns) rd = cells[addr(r, c)];
				default: ;
			endcase
			e.cursor_col = ccol;
			e.cursor_row = crow;
			e.cell_char = rd.ch;
			e.cell_fg = rd.fg;
			e.cell_bg = rd.bg;
			e.cell_style = rd.style;
			pending.push_back(e);
		endfunction

		function void check_response(rsp_t a);
			rsp_t e;
			if (pending.size() == 0) begin
				$error("unexpected response beat %p", a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.cursor_col !== e.cursor_col) begin
				$error("cursor_col exp %0d got %0d", e.cursor_col, a.cursor_col); errors++;
			end
			if (a.cursor_row !== e.cursor_row) begin
				$error("cursor_row exp %0d got %0d", e.cursor_row, a.cursor_row); errors++;
			end
			if (a.cell_char !== e.cell_char) begin
				$error("cell_char exp %0h got %0h", e.cell_char, a.cell_char); errors++;
			end
			if (a.cell_fg !== e.cell_fg) begin
				$error("cell_fg exp %0d got %0d", e.cell_fg, a.cell_fg); errors++;
			end
			if (a.cell_bg !== e.cell_bg) begin
				$error("cell_bg exp %0d got %0d", e.cell_bg, a.cell_bg); errors++;
			end
			if (a.cell_style !== e.cell_style) begin
				$error("cell_style exp %0d got %0d", e.cell_style, a.cell_style); errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	tts_req_if req_ch();
	tts_rsp_if rsp_ch();
	tts_cfg_if cfg_ch();
	screen_scoreboard screen = new();
	int hold_off = 0;
	bit stall_on = 1;

	text_terminal_screen_engine_core i_dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source), .cfg(cfg_ch.sink)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		req_ch.valid = 0; req_ch.data = '0;
		cfg_ch.valid = 0; cfg_ch.data = '0;
		rsp_ch.ready = 0;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) screen.check_response(rsp_ch.data);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			rsp_ch.ready <= 0;
		end else if (stall_on) begin
			rsp_ch.ready <= ($urandom_range(0, 3) != 0);
		end else begin
			rsp_ch.ready <= 1;
		end
	end

	task automatic send_req(req_t q);
		req_ch.valid <= 1;
		req_ch.data <= q;
		do @(posedge clk); while (!req_ch.ready);
		screen.note_request(q);
	endtask

	task automatic idle_req(int n);
		req_ch.valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		int guard;
		idle_req(1);
		guard = 0;
		while (screen.pending.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4000) @(posedge clk);
	endtask

	task automatic write_reg(logic [3:0] idx, logic [3:0] v);
		cfg_ch.valid <= 1;
		cfg_ch.data <= '{index: idx, data: v};
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 0;
		screen.write_reg(idx, v);
		@(posedge clk);
	endtask

	function automatic req_t mk(logic [3:0] t, logic [7:0] ch, int c, int r, bit d, bit s,
		logic [4:0] b);
		req_t q;
		q.req_type = t; q.char_code = ch; q.col_arg = c; q.row_arg = r;
		q.direction = d; q.scroll_enable = s; q.region_bottom = b;
		return q;
	endfunction

	function automatic req_t rand_req();
		req_t q;
		int k;
		q = req_t'({$urandom, $urandom});
		k = $urandom_range(0, 99);
		if (k < 40) q.req_type = REQ_PUT;
		else if (k < 95) q.req_type = $urandom_range(0, 9);
		else q.req_type = $urandom_range(10, 15);
		// Form feed and full clears are slow; keep them rare.
		if ((q.req_type == REQ_FF || q.req_type == REQ_CLRSCR) && $urandom_range(0, 3) != 0)
			q.req_type = REQ_READ;
		if ($urandom_range(0, 3) != 0) begin
			q.col_arg = $urandom_range(0, Columns + 1);
			q.row_arg = $urandom_range(0, Rows + 1);
		end
		if (q.req_type == REQ_CLRLN && $urandom_range(0, 1))
			q.col_arg = $urandom_range(Columns - 4, Columns - 1);
		if (q.req_type == REQ_WIN && $urandom_range(0, 1)) q.region_bottom = Rows;
		return q;
	endfunction

	initial begin
		bit [3:0] vals[4];
		bit held;
		held = 0;
		repeat (11) @(posedge clk);
		screen.clear_all();
		arst_n <= 1;
		@(posedge clk);
		// directed
		send_req(mk(REQ_READ, 0, 0, 0, 0, 0, 1));
		send_req(mk(REQ_PUT, 8'hff, 0, 0, 0, 0, 1));
		send_req(mk(REQ_PUT, 8'h00, 0, 0, 0, 0, 1));
		send_req(mk(REQ_READ, 0, 0, 0, 0, 0, 1));
		send_req(mk(REQ_TAB, 0, 0, 0, 0, 0, 1));
		send_req(mk(REQ_MOVE, 0, 127, 127, 0, 1, 1));
		send_req(mk(REQ_PUT, 8'h41, 0, 0, 0, 0, 1));
		send_req(mk(REQ_TAB, 0, 0, 0, 0, 0, 1));
		send_req(mk(REQ_MOVE, 0, -128, -128, 0, 1, 1));
		send_req(mk(REQ_MOVE, 0, 80, 24, 0, 0, 1));
		send_req(mk(REQ_PUT, 8'h42, 0, 0, 0, 0, 1));
		send_req(mk(REQ_READ, 0, 79, 23, 0, 0, 1));
		send_req(mk(REQ_READ, 0, 80, -1, 0, 0, 1));
		send_req(mk(REQ_CLRLN, 0, 40, 0, 1, 0, 1));
		send_req(mk(REQ_CLRLN, 0, 40, 23, 0, 0, 1));
		send_req(mk(REQ_CLRSCR, 0, 5, 10, 1, 0, 1));
		send_req(mk(REQ_CLRSCR, 0, -3, 30, 0, 0, 1));
		send_req(mk(REQ_SCRUP, 0, 0, 0, 0, 0, 1));
		send_req(mk(REQ_SCRDN, 0, 0, 0, 0, 0, 1));
		send_req(mk(REQ_WIN, 0, 0, 5, 0, 0, 20));
		send_req(mk(REQ_WIN, 0, 0, 20, 0, 0, 3));
		send_req(mk(REQ_MOVE, 0, 1, 1, 0, 1, 31));
		send_req(mk(REQ_MOVE, 0, 1, 30, 0, 1, 0));
		send_req(mk(REQ_FF, 0, 0, 0, 0, 0, 1));
		send_req(mk(4'd15, 0, 0, 0, 0, 0, 1));
		drain();
		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 0) vals = '{0, 0, 15, 15};
			else if (ph == 1) vals = '{1, 15, 0, 0};
			else vals = '{$urandom_range(0, 1), $urandom, $urandom, $urandom};
			write_reg(CFG_WRAP, vals[0]);
			write_reg(CFG_FG, vals[1]);
			write_reg(CFG_BG, vals[2]);
			write_reg(CFG_STYLE, vals[3]);
			for (int n = 0; n < 80; ) begin
				int burst;
				burst = $urandom_range(1, 12);
				for (int k = 0; k < burst; k++, n++) send_req(rand_req());
				if (ph == 2 && !held && n >= 40) begin
					held = 1;
					hold_off <= 400;
					for (int k = 0; k < 10; k++, n++) send_req(rand_req());
				end
				if (ph == 3 && n >= 40 && n < 52) begin
					req_ch.valid <= 0;
					while (screen.pending.size() != 0) @(posedge clk);
				end
				if ($urandom_range(0, 2) == 0) idle_req($urandom_range(1, 20));
			end
			stall_on = (ph != 1);
			drain();
		end
		if (screen.errors == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

	initial begin
		#200000000;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
